// File: design/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// Shared constants for the centered moving-average filter.
// ----------------------------------------------------------------------------
package cma_pkg;

  // width of the sample and timestamp fields on the ports
  localparam int unsigned FIELD_W = 32;

  // width of the half-window configuration register
  localparam int unsigned HALF_W = 4;

  // half window after reset
  localparam logic [HALF_W-1:0] RESET_HALF_WINDOW = 4'd2;

  // input transaction kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

endpackage

// File: design/cma_cell.sv
// ----------------------------------------------------------------------------
// cma_cell
// One window tap: holds a sample and its timestamp, shifts them to the next
// tap on every new sample, and drives its contents onto the drop and center
// buses when its position matches.
// ----------------------------------------------------------------------------
module cma_cell #(
  parameter int unsigned IDX     = 0,
  parameter int unsigned VALUE_W = 32,
  parameter int unsigned HW_W    = 4,
  parameter int unsigned WIDTH_W = 5
) (
  input  logic                            clk_i,
  input  logic                            shift_i,
  input  logic [HW_W-1:0]                 half_i,
  input  logic [WIDTH_W-1:0]              width_i,
  input  logic [VALUE_W-1:0]              value_i,
  input  logic [cma_pkg::FIELD_W-1:0]     time_i,
  output logic [VALUE_W-1:0]              value_o,
  output logic [cma_pkg::FIELD_W-1:0]     time_o,
  output logic [VALUE_W-1:0]              drop_value_o,
  output logic [cma_pkg::FIELD_W-1:0]     center_time_o
);

  logic [VALUE_W-1:0]          value_q;
  logic [cma_pkg::FIELD_W-1:0] time_q;
  logic                        is_oldest;
  logic                        is_center;

  // payload shifts along the chain, no reset needed
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      value_q <= value_i;
      time_q  <= time_i;
    end
  end

  // position decode: oldest entry of the window and the center entry
  assign is_oldest = (32'(width_i) == IDX + 1);
  assign is_center = (32'(half_i) == IDX);

  assign value_o       = value_q;
  assign time_o        = time_q;
  assign drop_value_o  = is_oldest ? value_q : '0;
  assign center_time_o = is_center ? time_q : '0;

endmodule

// File: design/cma_divider.sv
// ----------------------------------------------------------------------------
// cma_divider
// Radix-2 restoring divider: signed sum over unsigned window width,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cma_divider #(
  parameter int unsigned SUM_W   = 37,
  parameter int unsigned WIDTH_W = 5,
  parameter int unsigned Q_W     = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SUM_W-1:0]    dividend_i,
  input  logic [WIDTH_W-1:0]  divisor_i,
  output logic                done_o,
  output logic [Q_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               neg_q, neg_d;
  logic [WIDTH_W-1:0] div_q, div_d;
  logic [WIDTH_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0]   quo_q, quo_d;
  logic [WIDTH_W:0]   rem_sh;
  logic [WIDTH_W:0]   rem_sub;
  logic [Q_W-1:0]     mag;

  // one restoring step
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SUM_W);
      neg_d  = dividend_i[SUM_W-1];
      div_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i[SUM_W-1] ? (SUM_W'(0) - dividend_i) : dividend_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = rem_sub[WIDTH_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[WIDTH_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // apply the sign; the magnitude always fits the sample width
  assign mag        = quo_q[Q_W-1:0];
  assign quotient_o = neg_q ? (Q_W'(0) - mag) : mag;
  assign done_o     = done_q;

endmodule

// File: design/centered_moving_average_filter_unit.sv
// ----------------------------------------------------------------------------
// centered_moving_average_filter_unit
// Centered boxcar filter over timestamped Q16.16 samples: keeps the newest
// 2N+1 samples in a chain of taps with a running sum, and reports the raw
// sample and, once the window is full, the window average tagged with the
// timestamp of the center sample.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+---------------------------
//   in       | input     | in_valid_i / in_ready_o  | kind, sample_value, time
//   out      | output    | out_valid_o / out_ready_i| raw_*, filtered_*
//   cfg      | input     | cfg_we_i (no wait)       | cfg_wdata_i = half window
//
// A sample that fills the window passes through the bit-per-cycle divider
// (ST_DIV) and then ST_HOLD before its result enters the output register;
// other transactions go straight to ST_HOLD. A new transaction is taken only
// in ST_IDLE. The next transaction is taken while a result waits in the
// output register; a result stalls only when the output register is still
// occupied. Reset clears the window (no clearing pass) and sets the half
// window to 2.
// ----------------------------------------------------------------------------
module centered_moving_average_filter_unit #(
  parameter int unsigned MAX_HALF_WINDOW = 15,
  parameter int unsigned SAMPLE_WIDTH    = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 kind_i,
  input  logic signed [cma_pkg::FIELD_W-1:0]   sample_value_i,
  input  logic [cma_pkg::FIELD_W-1:0]          sample_time_i,
  input  logic                                 cfg_we_i,
  input  logic [cma_pkg::HALF_W-1:0]           cfg_wdata_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 raw_valid_o,
  output logic signed [cma_pkg::FIELD_W-1:0]   raw_value_o,
  output logic [cma_pkg::FIELD_W-1:0]          raw_time_o,
  output logic                                 filtered_valid_o,
  output logic signed [cma_pkg::FIELD_W-1:0]   filtered_value_o,
  output logic [cma_pkg::FIELD_W-1:0]          filtered_time_o
);

  localparam int unsigned FW      = cma_pkg::FIELD_W;
  localparam int unsigned SX_W    = (SAMPLE_WIDTH > FW) ? FW : SAMPLE_WIDTH;
  localparam int unsigned DEPTH   = 2 * MAX_HALF_WINDOW + 1;
  localparam int unsigned HW_W    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned WIDTH_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W   = SX_W + $clog2(DEPTH);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [cma_pkg::HALF_W-1:0] half_q;
  logic [WIDTH_W-1:0]        fill_q, fill_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic                      raw_ok_q;
  logic [SX_W-1:0]           raw_val_q;
  logic [FW-1:0]             raw_time_q;
  logic                      avg_ok_q;
  logic [SX_W-1:0]           avg_val_q;
  logic [FW-1:0]             avg_time_q;
  logic                      out_valid_q;

  logic [HW_W-1:0]           half_sat;
  logic [WIDTH_W-1:0]        win_width;
  logic                      accept;
  logic                      is_sample;
  logic                      shift;
  logic                      full;
  logic                      div_start;
  logic                      div_done;
  logic [SX_W-1:0]           quotient;
  logic [SX_W-1:0]           sx_val;
  logic [SUM_W-1:0]          sx_ext;
  logic [SUM_W-1:0]          drop_ext;
  logic [SX_W-1:0]           drop_val;
  logic [FW-1:0]             center_time;
  logic                      out_load;

  // tap chain wiring
  logic [SX_W-1:0] chain_val  [DEPTH+1];
  logic [FW-1:0]   chain_time [DEPTH+1];
  logic [SX_W-1:0] drop_tap   [DEPTH];
  logic [FW-1:0]   center_tap [DEPTH];

  // effective half window and window width
  assign half_sat  = (32'(half_q) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW)
                                                     : HW_W'(half_q);
  assign win_width = {half_sat, 1'b1};

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_sample  = (kind_i == cma_pkg::KIND_SAMPLE);
  assign shift      = accept && is_sample;

  // incoming sample, sign-extended from its used width
  assign sx_val = sample_value_i[SX_W-1:0];
  assign sx_ext = {{(SUM_W-SX_W){sx_val[SX_W-1]}}, sx_val};

  // chain of taps; tap 0 holds the newest sample
  assign chain_val[0]  = sx_val;
  assign chain_time[0] = sample_time_i;

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    cma_cell #(
      .IDX     (k),
      .VALUE_W (SX_W),
      .HW_W    (HW_W),
      .WIDTH_W (WIDTH_W)
    ) u_cell (
      .clk_i         (clk_i),
      .shift_i       (shift),
      .half_i        (half_sat),
      .width_i       (win_width),
      .value_i       (chain_val[k]),
      .time_i        (chain_time[k]),
      .value_o       (chain_val[k+1]),
      .time_o        (chain_time[k+1]),
      .drop_value_o  (drop_tap[k]),
      .center_time_o (center_tap[k])
    );
  end

  // merge the one-hot tap outputs
  always_comb begin
    drop_val    = '0;
    center_time = '0;
    for (int k = 0; k < DEPTH; k++) begin
      drop_val    = drop_val | drop_tap[k];
      center_time = center_time | center_tap[k];
    end
  end

  // running sum and fill count update for a new sample
  assign full     = (fill_q >= win_width);
  assign drop_ext = full ? {{(SUM_W-SX_W){drop_val[SX_W-1]}}, drop_val} : '0;
  assign sum_d    = sum_q - drop_ext + sx_ext;
  assign fill_d   = full ? fill_q : (fill_q + WIDTH_W'(1));
  assign div_start = shift && (fill_d >= win_width);

  cma_divider #(
    .SUM_W   (SUM_W),
    .WIDTH_W (WIDTH_W),
    .Q_W     (SX_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (win_width),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = div_start ? ST_DIV : ST_HOLD;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_HOLD) && (!out_valid_q || out_ready_i);

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      half_q      <= cma_pkg::RESET_HALF_WINDOW;
      fill_q      <= '0;
      sum_q       <= '0;
      raw_ok_q    <= 1'b0;
      avg_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        half_q   <= cfg_wdata_i;
        fill_q   <= '0;
        sum_q    <= '0;
        avg_ok_q <= 1'b0;
      end else if (accept && !is_sample) begin
        fill_q   <= '0;
        sum_q    <= '0;
        raw_ok_q <= 1'b0;
        avg_ok_q <= 1'b0;
      end else if (shift) begin
        fill_q   <= fill_d;
        sum_q    <= sum_d;
        raw_ok_q <= 1'b1;
      end else if (div_done) begin
        avg_ok_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // held values, qualified by the ok bits
  always_ff @(posedge clk_i) begin
    if (shift) begin
      raw_val_q  <= sx_val;
      raw_time_q <= sample_time_i;
    end
    if (div_done) begin
      avg_val_q  <= quotient;
      avg_time_q <= center_time;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      raw_valid_o      <= raw_ok_q;
      raw_value_o      <= raw_ok_q ? FW'($signed(raw_val_q)) : '0;
      raw_time_o       <= raw_ok_q ? raw_time_q : '0;
      filtered_valid_o <= avg_ok_q;
      filtered_value_o <= avg_ok_q ? FW'($signed(avg_val_q)) : '0;
      filtered_time_o  <= avg_ok_q ? avg_time_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
